/* src/bsca_pkg.sv */
// Shared types, codes and constants of the bitmap size-class allocator.
`timescale 1ns / 1ps

package bsca_pkg;

  localparam int ADDR_W      = 48;
  localparam int SIZE_W      = 32;
  localparam int SHIFT_W     = 5;
  localparam int STATUS_W    = 3;
  localparam int CLASS_OUT_W = 2;
  localparam int CFG_IDX_W   = 3;

  // Register map of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_FIRST = 3'd1;
  localparam int                   NUM_SHIFT_REGS  = 4;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED   = 3'd0,
    ST_NO_FIT      = 3'd1,
    ST_CLASS_FULL  = 3'd2,
    ST_FREED       = 3'd3,
    ST_OUTSIDE     = 3'd4,
    ST_NOT_ALLOC   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CLASS,
    FSM_SCAN,
    FSM_GRANT,
    FSM_FREE
  } fsm_e;

  // Reset entry-size shift of a class: 7, 8, 9, 12, then one more per extra class.
  function automatic logic [SHIFT_W-1:0] rst_shift(input int c);
    logic [SHIFT_W-1:0] s;
    if (c == 0) begin
      s = 5'd7;
    end else if (c == 1) begin
      s = 5'd8;
    end else if (c == 2) begin
      s = 5'd9;
    end else begin
      s = SHIFT_W'(12 + (c - 3));
    end
    return s;
  endfunction

endpackage

/* src/bitmap_size_class_allocator.sv */
// Bitmap size-class allocator: class search, bitmap memory scan and free path.
`timescale 1ns / 1ps

// Slab-style allocator with NUM_CLASSES size classes. Class c owns the region
// of REGION_BYTES bytes at pool_base + c*REGION_BYTES, cut into entries of
// 2^shift bytes, tracked by a used-entry bitmap held in one synchronous
// simple dual-port memory (one read, one write per cycle, registered read
// data). A request is taken when start is high and busy is low; its
// result shows on status_o / granted_address_o / class_index_o for exactly
// one cycle with done_o high, and the receiver cannot hold it off.
// The class search walks one class per cycle. A free whose entry lies in a
// touched word issues its memory read in the last search cycle and clears
// the entry's bit in the next cycle if it was set. An allocate scans the
// class's bitmap words one per cycle through the memory read port,
// pipelined, and stops at the first word with a free entry, which a grant
// step then writes back with that entry marked used; with the defaults the
// smallest class has 128 words. The result appears the cycle after the last
// step and busy is already low in that cycle.
// No clearing pass is needed after reset or after a class_shift write: each
// class keeps a count of bitmap words touched since it was cleared; words
// beyond it read as all-free. MAP_WORD_BITS must be a power of two.
// Configuration writes (always ready) must only be made while busy is low.

module bitmap_size_class_allocator #(
  parameter int NUM_CLASSES     = 4,
  parameter int REGION_BYTES    = 1048576,
  parameter int MAP_WORD_BITS   = 64,
  parameter int MIN_CLASS_SHIFT = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 action_i,
  input  logic [bsca_pkg::SIZE_W-1:0]          request_bytes_i,
  input  logic [bsca_pkg::ADDR_W-1:0]          block_address_i,
  // result channel
  output logic                                 done_o,
  output logic [bsca_pkg::STATUS_W-1:0]        status_o,
  output logic [bsca_pkg::ADDR_W-1:0]          granted_address_o,
  output logic [bsca_pkg::CLASS_OUT_W-1:0]     class_index_o,
  // configuration channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bsca_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bsca_pkg::ADDR_W-1:0]          cfg_data_i
);

  localparam int AW_ADDR   = bsca_pkg::ADDR_W;
  localparam int SW        = bsca_pkg::SHIFT_W;
  localparam int CW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int WB        = MAP_WORD_BITS;
  localparam int BW        = $clog2(WB);
  localparam int MAXE      = REGION_BYTES >> MIN_CLASS_SHIFT;
  localparam int WPC       = (MAXE + WB - 1) / WB;
  localparam int MAP_WORDS = NUM_CLASSES * WPC;
  localparam int MAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WIW       = $clog2(WPC + 1);
  localparam int CNTW      = $clog2(MAXE + 1);
  localparam int RBW       = $clog2(REGION_BYTES);
  localparam int RVW       = RBW + 1;
  localparam int LW        = ((CNTW > BW) ? CNTW : BW) + 1;

  localparam logic [RVW-1:0]     REGION_V = RVW'(REGION_BYTES);
  localparam logic [AW_ADDR-1:0] REGION_A = AW_ADDR'(REGION_BYTES);

  // shift below the minimum acts as the minimum
  function automatic logic [SW-1:0] eff_shift(input logic [SW-1:0] s);
    return (s < SW'(MIN_CLASS_SHIFT)) ? SW'(MIN_CLASS_SHIFT) : s;
  endfunction

  function automatic logic [CNTW-1:0] entries(input logic [SW-1:0] sh);
    logic [RVW-1:0] v;
    v = REGION_V >> sh;
    return CNTW'(v);
  endfunction

  function automatic logic [MAW-1:0] map_addr(input logic [CW-1:0] c,
                                              input logic [WIW-1:0] w);
    return MAW'(MAW'(c) * MAW'(WPC) + MAW'(w));
  endfunction

  // ---------------------------------------------------------------------
  // Configuration and per-class state
  // ---------------------------------------------------------------------
  logic [AW_ADDR-1:0] pool_base_q;
  logic [SW-1:0]      shift_q [NUM_CLASSES];
  logic [WIW-1:0]     fill_q  [NUM_CLASSES];  // bitmap words touched since clear
  logic [CNTW-1:0]    free_q  [NUM_CLASSES];  // free entries

  // ---------------------------------------------------------------------
  // Request and walk registers
  // ---------------------------------------------------------------------
  bsca_pkg::fsm_e     state_q, state_d;
  logic               action_q;
  logic [bsca_pkg::SIZE_W-1:0] bytes_q;
  logic [AW_ADDR-1:0] addr_q;
  logic [CW-1:0]      cls_q;
  logic [AW_ADDR-1:0] base_q;     // region base of cls_q
  logic [SW-1:0]      sh_q;
  logic [CNTW-1:0]    n_q;
  logic [WIW-1:0]     nw_q;
  logic [WIW-1:0]     wi_q;       // next word to read
  logic [WIW-1:0]     wc_q;       // word whose read data is back
  logic               chk_v_q;
  logic               hw_q;       // that word lies in the touched part
  logic [WIW-1:0]     gw_q;
  logic [CNTW-1:0]    gidx_q;
  logic [WB-1:0]      gdata_q;

  // result registers
  logic                             done_q;
  logic [bsca_pkg::STATUS_W-1:0]    status_q;
  logic [AW_ADDR-1:0]               gaddr_q;
  logic [bsca_pkg::CLASS_OUT_W-1:0] cidx_q;

  // bitmap memory
  logic [WB-1:0]  map_mem [MAP_WORDS];
  logic [WB-1:0]  rdata_q;
  logic           rd_en, wr_en;
  logic [MAW-1:0] rd_addr, wr_addr;
  logic [WB-1:0]  wr_data;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = (state_q != bsca_pkg::FSM_IDLE);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Datapath decisions
  // ---------------------------------------------------------------------
  logic [SW-1:0]      cur_sh;
  logic [CNTW-1:0]    cur_n;
  logic               fits, last_cls, in_reg;
  logic [AW_ADDR-1:0] off;
  logic [CNTW-1:0]    fidx;
  logic [WIW-1:0]     fword;
  logic [WIW-1:0]     cur_nw;
  logic [WB-1:0]      word_v, mask, freebits;
  logic [LW-1:0]      left;
  logic               found;
  logic [BW-1:0]      fbit;
  logic [WB-1:0]      fbit_mask;

  logic                          fin;
  bsca_pkg::status_e             fin_status;
  logic                          fin_cls_zero;
  logic [AW_ADDR-1:0]            fin_addr;

  always_comb begin
    cur_sh   = eff_shift(shift_q[cls_q]);
    cur_n    = entries(cur_sh);
    cur_nw   = WIW'((LW'(cur_n) + LW'(WB - 1)) >> BW);
    fits     = ({1'b0, bytes_q} <= ((bsca_pkg::SIZE_W + 1)'(1) << cur_sh));
    last_cls = (cls_q == CW'(NUM_CLASSES - 1));
    off      = addr_q - base_q;
    in_reg   = (off < REGION_A);
    fidx     = CNTW'(off[RBW-1:0] >> cur_sh);
    fword    = WIW'(fidx >> BW);

    // scan check stage
    word_v = hw_q ? rdata_q : '0;
    left   = LW'(n_q) - (LW'(wc_q) << BW);
    if (left < LW'(WB)) begin
      mask = (WB'(1) << BW'(left)) - WB'(1);
    end else begin
      mask = '1;
    end
    freebits = ~word_v & mask;
    found    = |freebits;
    fbit     = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (freebits[i]) begin
        fbit = BW'(i);
      end
    end
    fbit_mask = WB'(1) << BW'(gidx_q);
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsca_pkg::FSM_IDLE: begin
        if (accept) state_d = bsca_pkg::FSM_CLASS;
      end
      bsca_pkg::FSM_CLASS: begin
        if (action_q == bsca_pkg::ACT_ALLOC) begin
          if (fits) begin
            state_d = (free_q[cls_q] == '0) ? bsca_pkg::FSM_IDLE : bsca_pkg::FSM_SCAN;
          end else if (last_cls) begin
            state_d = bsca_pkg::FSM_IDLE;
          end
        end else begin
          if (in_reg) begin
            if (fidx < cur_n && fword < fill_q[cls_q]) begin
              state_d = bsca_pkg::FSM_FREE;
            end else begin
              state_d = bsca_pkg::FSM_IDLE;
            end
          end else if (last_cls) begin
            state_d = bsca_pkg::FSM_IDLE;
          end
        end
      end
      bsca_pkg::FSM_SCAN: begin
        if (chk_v_q && found) begin
          state_d = bsca_pkg::FSM_GRANT;
        end else if ((chk_v_q && wc_q == nw_q - WIW'(1)) || (!chk_v_q && wi_q >= nw_q)) begin
          state_d = bsca_pkg::FSM_IDLE;
        end
      end
      bsca_pkg::FSM_GRANT: state_d = bsca_pkg::FSM_IDLE;
      bsca_pkg::FSM_FREE:  state_d = bsca_pkg::FSM_IDLE;
      default:             state_d = bsca_pkg::FSM_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Outputs of the state machine: memory ports and finishing result
  // ---------------------------------------------------------------------
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = map_addr(cls_q, wi_q);
    wr_en        = 1'b0;
    wr_addr      = map_addr(cls_q, gw_q);
    wr_data      = gdata_q;
    fin          = 1'b0;
    fin_status   = bsca_pkg::ST_ALLOCATED;
    fin_cls_zero = 1'b0;
    fin_addr     = '0;
    unique case (state_q)
      bsca_pkg::FSM_IDLE: begin
      end
      bsca_pkg::FSM_CLASS: begin
        if (action_q == bsca_pkg::ACT_ALLOC) begin
          if (fits) begin
            if (free_q[cls_q] == '0) begin
              fin        = 1'b1;
              fin_status = bsca_pkg::ST_CLASS_FULL;
            end
          end else if (last_cls) begin
            fin          = 1'b1;
            fin_status   = bsca_pkg::ST_NO_FIT;
            fin_cls_zero = 1'b1;
          end
        end else begin
          if (in_reg) begin
            if (fidx < cur_n && fword < fill_q[cls_q]) begin
              rd_en   = 1'b1;
              rd_addr = map_addr(cls_q, fword);
            end else begin
              // beyond the class's entries, or in an untouched (all free) word
              fin        = 1'b1;
              fin_status = bsca_pkg::ST_NOT_ALLOC;
            end
          end else if (last_cls) begin
            fin          = 1'b1;
            fin_status   = bsca_pkg::ST_OUTSIDE;
            fin_cls_zero = 1'b1;
          end
        end
      end
      bsca_pkg::FSM_SCAN: begin
        rd_en = (wi_q < nw_q);
        if (!(chk_v_q && found)) begin
          if ((chk_v_q && wc_q == nw_q - WIW'(1)) || (!chk_v_q && wi_q >= nw_q)) begin
            fin        = 1'b1;
            fin_status = bsca_pkg::ST_CLASS_FULL;
          end
        end
      end
      bsca_pkg::FSM_GRANT: begin
        wr_en      = 1'b1;
        fin        = 1'b1;
        fin_status = bsca_pkg::ST_ALLOCATED;
        fin_addr   = base_q + (AW_ADDR'(gidx_q) << sh_q);
      end
      bsca_pkg::FSM_FREE: begin
        fin     = 1'b1;
        wr_data = rdata_q & ~fbit_mask;
        if ((rdata_q & fbit_mask) != '0) begin
          wr_en      = 1'b1;
          fin_status = bsca_pkg::ST_FREED;
        end else begin
          fin_status = bsca_pkg::ST_NOT_ALLOC;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Bitmap memory
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= map_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Control and per-class state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsca_pkg::FSM_IDLE;
      done_q      <= 1'b0;
      pool_base_q <= '0;
      chk_v_q     <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        shift_q[c] <= bsca_pkg::rst_shift(c);
        fill_q[c]  <= '0;
        free_q[c]  <= entries(eff_shift(bsca_pkg::rst_shift(c)));
      end
    end else begin
      state_q <= state_d;
      done_q  <= fin;

      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == bsca_pkg::CFG_POOL_BASE) begin
          pool_base_q <= cfg_data_i;
        end
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (c < bsca_pkg::NUM_SHIFT_REGS &&
              cfg_index_i == bsca_pkg::CFG_IDX_W'(int'(bsca_pkg::CFG_SHIFT_FIRST) + c)) begin
            // rewriting a shift empties the class
            shift_q[c] <= cfg_data_i[SW-1:0];
            fill_q[c]  <= '0;
            free_q[c]  <= entries(eff_shift(cfg_data_i[SW-1:0]));
          end
        end
      end

      if (state_q == bsca_pkg::FSM_SCAN) begin
        chk_v_q <= (wi_q < nw_q);
      end else begin
        chk_v_q <= 1'b0;
      end

      if (state_q == bsca_pkg::FSM_GRANT) begin
        free_q[cls_q] <= free_q[cls_q] - CNTW'(1);
        if (gw_q == fill_q[cls_q]) begin
          fill_q[cls_q] <= fill_q[cls_q] + WIW'(1);
        end
      end
      if (state_q == bsca_pkg::FSM_FREE && wr_en) begin
        free_q[cls_q] <= free_q[cls_q] + CNTW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request payload and walk registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      bytes_q  <= request_bytes_i;
      addr_q   <= block_address_i;
      cls_q    <= '0;
      base_q   <= pool_base_q;
    end

    if (state_q == bsca_pkg::FSM_CLASS) begin
      if (action_q == bsca_pkg::ACT_ALLOC) begin
        if (fits) begin
          sh_q <= cur_sh;
          n_q  <= cur_n;
          nw_q <= cur_nw;
          wi_q <= '0;
        end else begin
          cls_q  <= cls_q + CW'(1);
          base_q <= base_q + REGION_A;
        end
      end else begin
        if (in_reg) begin
          gw_q   <= fword;
          gidx_q <= fidx;
        end else begin
          cls_q  <= cls_q + CW'(1);
          base_q <= base_q + REGION_A;
        end
      end
    end

    if (state_q == bsca_pkg::FSM_SCAN) begin
      if (wi_q < nw_q) begin
        wi_q <= wi_q + WIW'(1);
      end
      wc_q <= wi_q;
      hw_q <= (wi_q < fill_q[cls_q]);
      if (chk_v_q && found) begin
        gw_q    <= wc_q;
        gidx_q  <= (CNTW'(wc_q) << BW) | CNTW'(fbit);
        gdata_q <= word_v | (WB'(1) << fbit);
      end
    end

    if (fin) begin
      status_q <= fin_status;
      gaddr_q  <= fin_addr;
      cidx_q   <= fin_cls_zero ? '0 : bsca_pkg::CLASS_OUT_W'(cls_q);
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign granted_address_o = gaddr_q;
  assign class_index_o     = cidx_q;

endmodule

/* sim/bsca_checker.sv */
// Reply predictor and result checker for the bitmap size-class allocator.
`timescale 1ns / 1ps

module bsca_checker #(
  parameter int NUM_CLASSES     = 4,
  parameter int REGION_BYTES    = 1048576,
  parameter int MAP_WORD_BITS   = 64,
  parameter int MIN_CLASS_SHIFT = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic                                 action_i,
  input  logic [bsca_pkg::SIZE_W-1:0]          request_bytes_i,
  input  logic [bsca_pkg::ADDR_W-1:0]          block_address_i,
  input  logic                                 done_i,
  input  logic [bsca_pkg::STATUS_W-1:0]        status_i,
  input  logic [bsca_pkg::ADDR_W-1:0]          granted_address_i,
  input  logic [bsca_pkg::CLASS_OUT_W-1:0]     class_index_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [bsca_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bsca_pkg::ADDR_W-1:0]          cfg_data_i,
  output int                                   errors_o,
  output int                                   pending_o
);

  localparam int AW          = bsca_pkg::ADDR_W;
  localparam int SW          = bsca_pkg::SHIFT_W;
  localparam int COW         = bsca_pkg::CLASS_OUT_W;
  localparam int ENTRIES_MAX = REGION_BYTES >> MIN_CLASS_SHIFT;

  typedef struct packed {
    bsca_pkg::status_e status;
    logic [AW-1:0]     addr;
    logic [COW-1:0]    cls;
  } reply_t;

  logic [AW-1:0]      pool_base_q;
  logic [SW-1:0]      shift_q [NUM_CLASSES];
  bit                 used_q  [NUM_CLASSES][ENTRIES_MAX];
  int unsigned        free_q  [NUM_CLASSES];
  reply_t             replies_q [$];

  function automatic int unsigned eff_shift(int c);
    return (shift_q[c] < MIN_CLASS_SHIFT) ? MIN_CLASS_SHIFT : int'(shift_q[c]);
  endfunction

  function automatic longint unsigned entries_of(int c);
    longint unsigned region;
    region = 64'(REGION_BYTES);
    return region >> eff_shift(c);
  endfunction

  function automatic logic [AW-1:0] region_base(int c);
    logic [AW-1:0] span;
    span = AW'(c * REGION_BYTES);
    return pool_base_q + span;
  endfunction

  task automatic clear_class(int c);
    for (int i = 0; i < ENTRIES_MAX; i++) used_q[c][i] = 1'b0;
    free_q[c] = 32'(entries_of(c));
  endtask

  task automatic reset_model();
    pool_base_q = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (c == 0) begin
        shift_q[c] = 5'd7;
      end else if (c == 1) begin
        shift_q[c] = 5'd8;
      end else if (c == 2) begin
        shift_q[c] = 5'd9;
      end else begin
        shift_q[c] = SW'(12 + (c - 3));
      end
      clear_class(c);
    end
  endtask

  task automatic write_register(logic [bsca_pkg::CFG_IDX_W-1:0] idx, logic [AW-1:0] data);
    int c;
    if (idx == bsca_pkg::CFG_POOL_BASE) begin
      pool_base_q = data;
    end else if (idx >= bsca_pkg::CFG_SHIFT_FIRST &&
                 idx < bsca_pkg::CFG_SHIFT_FIRST + bsca_pkg::NUM_SHIFT_REGS) begin
      c = int'(idx) - int'(bsca_pkg::CFG_SHIFT_FIRST);
      // a shift write also empties that class
      if (c < NUM_CLASSES) begin
        shift_q[c] = data[SW-1:0];
        clear_class(c);
      end
    end
  endtask

  // Applies one request to the predicted state and returns its reply.
  function automatic reply_t serve_request(bsca_pkg::action_e act,
                                           logic [bsca_pkg::SIZE_W-1:0] size,
                                           logic [AW-1:0] addr);
    reply_t          r;
    int unsigned     sh;
    longint unsigned sz;
    longint unsigned n;
    longint unsigned idx;
    logic [AW-1:0]   idx_a;
    logic [AW-1:0]   off;
    bit              settled;
    r.status = bsca_pkg::ST_NO_FIT;
    r.addr   = '0;
    r.cls    = '0;
    settled  = 1'b0;
    sz       = 64'(size);
    if (act == bsca_pkg::ACT_ALLOC) begin
      for (int c = 0; c < NUM_CLASSES && !settled; c++) begin
        sh = eff_shift(c);
        if (sz <= (64'd1 << sh)) begin
          // first fitting class only, no fall-back
          settled  = 1'b1;
          r.cls    = c[COW-1:0];
          r.status = bsca_pkg::ST_CLASS_FULL;
          if (free_q[c] != 0) begin
            n   = entries_of(c);
            idx = 0;
            while (idx < n && used_q[c][idx]) idx++;
            if (idx < n) begin
              used_q[c][idx] = 1'b1;
              free_q[c]--;
              idx_a    = idx[AW-1:0];
              r.status = bsca_pkg::ST_ALLOCATED;
              r.addr   = region_base(c) + (idx_a << sh);
            end
          end
        end
      end
    end else begin
      r.status = bsca_pkg::ST_OUTSIDE;
      for (int c = 0; c < NUM_CLASSES && !settled; c++) begin
        off = addr - region_base(c);
        if (off < REGION_BYTES) begin
          settled  = 1'b1;
          r.cls    = c[COW-1:0];
          r.status = bsca_pkg::ST_NOT_ALLOC;
          idx      = 64'(off >> eff_shift(c));
          if (idx < entries_of(c) && used_q[c][idx]) begin
            used_q[c][idx] = 1'b0;
            free_q[c]++;
            r.status = bsca_pkg::ST_FREED;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic flag(string what, logic [63:0] want, logic [63:0] got);
    errors_o++;
    if (errors_o <= 10) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      reset_model();
      replies_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (done_i === 1'b1) begin
        if (replies_q.size() == 0) begin
          flag("unrequested result, status", '0, 64'(status_i));
        end else begin
          want = replies_q.pop_front();
          if (status_i !== want.status) flag("status", 64'(want.status), 64'(status_i));
          if (granted_address_i !== want.addr) begin
            flag("granted_address", 64'(want.addr), 64'(granted_address_i));
          end
          if (class_index_i !== want.cls) flag("class_index", 64'(want.cls), 64'(class_index_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (start_i && !busy_i) begin
        replies_q.push_back(serve_request(bsca_pkg::action_e'(action_i), request_bytes_i,
                                          block_address_i));
      end
      pending_o = replies_q.size();
    end
  end

endmodule

/* sim/tb_bitmap_size_class_allocator.sv */
// Testbench top: clock, reset, request and register stimulus, and the verdict.
`timescale 1ns / 1ps

module tb_bitmap_size_class_allocator;

  localparam int NUM_CLASSES     = 4;
  localparam int REGION_BYTES    = 1048576;
  localparam int MAP_WORD_BITS   = 64;
  localparam int MIN_CLASS_SHIFT = 7;

  localparam int AW  = bsca_pkg::ADDR_W;
  localparam int SZW = bsca_pkg::SIZE_W;
  localparam int SW  = bsca_pkg::SHIFT_W;
  localparam int CIW = bsca_pkg::CFG_IDX_W;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic                                 action;
  logic [SZW-1:0]                       request_bytes;
  logic [AW-1:0]                        block_address;
  logic                                 done;
  logic [bsca_pkg::STATUS_W-1:0]        status;
  logic [AW-1:0]                        granted_address;
  logic [bsca_pkg::CLASS_OUT_W-1:0]     class_index;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [CIW-1:0]                       cfg_index;
  logic [AW-1:0]                        cfg_data;

  int errors;
  int pending;

  // Register values as last written, used to aim requests at real entries.
  logic [AW-1:0] cur_base;
  logic [SW-1:0] cur_shift [NUM_CLASSES];

  // While nonzero, requests go back to back with no idle cycles.
  int burst_left;

  bitmap_size_class_allocator #(
    .NUM_CLASSES     (NUM_CLASSES),
    .REGION_BYTES    (REGION_BYTES),
    .MAP_WORD_BITS   (MAP_WORD_BITS),
    .MIN_CLASS_SHIFT (MIN_CLASS_SHIFT)
  ) u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start             (start),
    .busy              (busy),
    .action_i          (action),
    .request_bytes_i   (request_bytes),
    .block_address_i   (block_address),
    .done_o            (done),
    .status_o          (status),
    .granted_address_o (granted_address),
    .class_index_o     (class_index),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  bsca_checker #(
    .NUM_CLASSES     (NUM_CLASSES),
    .REGION_BYTES    (REGION_BYTES),
    .MAP_WORD_BITS   (MAP_WORD_BITS),
    .MIN_CLASS_SHIFT (MIN_CLASS_SHIFT)
  ) u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_i            (busy),
    .action_i          (action),
    .request_bytes_i   (request_bytes),
    .block_address_i   (block_address),
    .done_i            (done),
    .status_i          (status),
    .granted_address_i (granted_address),
    .class_index_i     (class_index),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .errors_o          (errors),
    .pending_o         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: reports a failure if the run has not finished before it fires.
  initial begin
    #4_000_000;
    $display("** bitmap_size_class_allocator: FAILED **");
    $finish;
  end

  function automatic logic [AW-1:0] rnd48();
    return AW'({$urandom, $urandom});
  endfunction

  // Shifts below the minimum behave as the minimum.
  function automatic int entry_shift(int c);
    return (cur_shift[c] < MIN_CLASS_SHIFT) ? MIN_CLASS_SHIFT : int'(cur_shift[c]);
  endfunction

  // Mostly legal entry sizes, sometimes anything the 5-bit field holds.
  function automatic logic [SW-1:0] pick_shift();
    if ($urandom_range(0, 4) == 0) return SW'($urandom_range(0, 31));
    return SW'($urandom_range(7, 20));
  endfunction

  // One request. Inputs move on the falling edge; the request is taken at the
  // first rising edge with busy low. start stays high across back-to-back
  // requests and is only dropped for an idle gap, during which the payload
  // carries junk that the block must ignore.
  task automatic send_item(bsca_pkg::action_e act, logic [SZW-1:0] size, logic [AW-1:0] addr);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 30);
    end
    if (gap != 0) begin
      start         = 1'b0;
      action        = 1'($urandom_range(0, 1));
      request_bytes = $urandom;
      block_address = rnd48();
      repeat (gap) @(negedge clk);
    end
    action        = act;
    request_bytes = size;
    block_address = addr;
    start         = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stop issuing and wait until every predicted reply has shown up.
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CIW-1:0] idx, logic [AW-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == bsca_pkg::CFG_POOL_BASE) begin
      cur_base = data;
    end else if (idx >= bsca_pkg::CFG_SHIFT_FIRST &&
                 idx < bsca_pkg::CFG_SHIFT_FIRST + bsca_pkg::NUM_SHIFT_REGS) begin
      cur_shift[idx - bsca_pkg::CFG_SHIFT_FIRST] = data[SW-1:0];
    end
  endtask

  // New register setting, written only with the block idle. mask picks the
  // registers to write (bit 0 pool_base, bits 1..4 the shifts); a shift write
  // empties its class, so a partial mask keeps other classes' bitmaps. Shift
  // data carries random upper bits, and every setting also pokes an unused
  // register index with random data.
  task automatic apply_setting(logic [AW-1:0] base, logic [SW-1:0] s0,
                               logic [SW-1:0] s1, logic [SW-1:0] s2,
                               logic [SW-1:0] s3, logic [4:0] mask);
    logic [AW-1:0] junk;
    drain();
    junk = rnd48();
    if (mask[0]) cfg_write(bsca_pkg::CFG_POOL_BASE, base);
    if (mask[1]) cfg_write(bsca_pkg::CFG_SHIFT_FIRST, {junk[AW-1:SW], s0});
    if (mask[2]) cfg_write(CIW'(bsca_pkg::CFG_SHIFT_FIRST + 1), {junk[AW-1:SW], s1});
    if (mask[3]) cfg_write(CIW'(bsca_pkg::CFG_SHIFT_FIRST + 2), {junk[AW-1:SW], s2});
    if (mask[4]) cfg_write(CIW'(bsca_pkg::CFG_SHIFT_FIRST + 3), {junk[AW-1:SW], s3});
    cfg_write(CIW'(bsca_pkg::CFG_SHIFT_FIRST + bsca_pkg::NUM_SHIFT_REGS + $urandom_range(0, 2)),
              rnd48());
  endtask

  // Random request aimed at one class. Allocations sit on and around the
  // class size boundaries; frees mostly hit low entries, since allocation is
  // lowest-first, with some unaligned, some anywhere in the region, some
  // fully random and some just outside the pools.
  task automatic random_item();
    int                c;
    int                sh;
    longint unsigned   n;
    longint unsigned   k_max;
    logic [AW-1:0]     off;
    logic [AW-1:0]     span;
    logic [AW-1:0]     addr;
    logic [SZW-1:0]    size;
    c     = $urandom_range(0, NUM_CLASSES - 1);
    sh    = entry_shift(c);
    n     = 64'(REGION_BYTES) >> sh;
    k_max = (n < 80) ? n : 80;
    span  = AW'(c * REGION_BYTES);
    if ($urandom_range(0, 99) < 60) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: size = SZW'((64'd1 << sh) - 64'($urandom_range(0, 3)));
        4, 5:       size = SZW'((64'd1 << sh) + 64'd1);
        6, 7:       size = $urandom_range(0, 32'd1 << sh);
        8:          size = $urandom;
        default:    size = '0;
      endcase
      send_item(bsca_pkg::ACT_ALLOC, size, rnd48());
    end else begin
      off = (k_max == 0) ? '0 : (AW'($urandom_range(0, 32'(k_max - 1))) << sh);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: addr = cur_base + span + off;
        6:       addr = cur_base + span + off + AW'($urandom_range(1, (32'd1 << sh) - 1));
        7:       addr = cur_base + span + AW'($urandom_range(0, REGION_BYTES - 1));
        8:       addr = rnd48();
        default: begin
          if ($urandom_range(0, 1) != 0) begin
            addr = cur_base + AW'(NUM_CLASSES * REGION_BYTES) + AW'($urandom_range(0, 255));
          end else begin
            addr = cur_base - AW'(1) - AW'($urandom_range(0, 255));
          end
        end
      endcase
      send_item(bsca_pkg::ACT_FREE, $urandom, addr);
    end
  endtask

  // Random requests under the current setting, with one full pause halfway.
  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      random_item();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    action        = bsca_pkg::ACT_ALLOC;
    request_bytes = '0;
    block_address = '0;
    cfg_valid     = 1'b0;
    cfg_index     = bsca_pkg::CFG_POOL_BASE;
    cfg_data      = '0;
    burst_left    = 0;
    cur_base      = '0;
    cur_shift[0]  = 5'd7;
    cur_shift[1]  = 5'd8;
    cur_shift[2]  = 5'd9;
    cur_shift[3]  = 5'd12;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed requests on the reset setting: base 0, entries 128/256/512/4096.
    // Size edges of every class, zero size and the largest size (no fit).
    send_item(bsca_pkg::ACT_ALLOC, 32'd0, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd1, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd128, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd129, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd256, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd257, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd512, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd513, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd4096, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'd4097, rnd48());
    send_item(bsca_pkg::ACT_ALLOC, 32'hFFFF_FFFF, rnd48());
    // First byte of the first region, then the same entry again (double free).
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'h0);
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'h0);
    // Unaligned frees land on the entry that holds the address.
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'h85);
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'h10_01FF);
    // Just past the last region, and the top address (offset wraps).
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'h40_0000);
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'hFFFF_FFFF_FFFF);
    // Last byte of the last region, entry never allocated.
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'h3F_FFFF);
    // Freed entry 0 is handed out again.
    send_item(bsca_pkg::ACT_ALLOC, 32'd0, rnd48());
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'h20_0000);
    send_item(bsca_pkg::ACT_FREE, $urandom, 48'h30_1000);

    // Few entries per class: classes fill up and double frees are common.
    apply_setting(48'h1234_5670_0000, 5'd17, 5'd18, 5'd19, 5'd20, 5'b11111);
    random_phase(30);
    // Regions wrap past the top of the address space; shift 0 acts as the
    // minimum, shift 31 gives a class with no entries that still answers full.
    apply_setting(48'hFFFF_FFF0_0000, 5'd0, 5'd7, 5'd31, 5'd20, 5'b11111);
    random_phase(30);
    // Largest, unaligned base with one entry per class.
    apply_setting(48'hFFFF_FFFF_FFFF, 5'd20, 5'd20, 5'd20, 5'd20, 5'b11111);
    random_phase(20);
    // Back to small entries: a run of tiny allocations pushes the lowest-free
    // scan past the first bitmap words before the mixed traffic.
    apply_setting(48'h0, 5'd7, 5'd8, 5'd9, 5'd12, 5'b11111);
    repeat (150) send_item(bsca_pkg::ACT_ALLOC, $urandom_range(0, 128), rnd48());
    random_phase(40);
    // Random settings; partial masks keep some classes' bitmaps populated.
    repeat (4) begin
      apply_setting(rnd48(), pick_shift(), pick_shift(), pick_shift(), pick_shift(),
                    5'($urandom_range(1, 31)));
      random_phase(30);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("** bitmap_size_class_allocator: PASSED **");
    end else begin
      $display("** bitmap_size_class_allocator: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bsca_pkg.sv
src/bitmap_size_class_allocator.sv
sim/bsca_checker.sv
sim/tb_bitmap_size_class_allocator.sv
